// File: hw/rtl/mrt_pkg.sv
// Shared types and constants for the missing range tracker.
`timescale 1ns / 1ps
`default_nettype none
package mrt_pkg;
  localparam int MaxGaps    = 16;
  localparam int OffsetBits = 40;
  localparam int LengthBits = 32;
  localparam int FuncBits   = 2;
  localparam logic [39:0] LimitReset = 40'hFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    FUNC_MARK  = 2'd0,
    FUNC_CHECK = 2'd1,
    FUNC_FIND  = 2'd2,
    FUNC_CLEAR = 2'd3
  } func_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the item
    logic clear;   // reload the initial range
    logic scan;    // examine entry at scan index and emit into the new table
    logic start;   // reset scan and write indexes
    logic commit;  // copy the scan copy back
  } dp_cmd_t;

  typedef struct packed {
    logic scan_done;  // scan index has reached gap count, or a mark was refused
    logic copy_done;
    logic refuse;     // split needed while full
  } dp_sts_t;
endpackage
`default_nettype wire

// File: hw/rtl/mrt_if.sv
// Valid/ready channel interface.
`timescale 1ns / 1ps
`default_nettype none
interface mrt_if #(parameter int W = 1) (input wire logic clk);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/missing_range_tracker.sv
// Top level of the missing range tracker.
`timescale 1ns / 1ps
`default_nettype none
// Tracks a sorted table of missing half-open byte ranges, at most MAX_GAPS
// entries, one item at a time. A check or find item passes from acceptance
// through a scan of the table entries one at a time through a single compare
// unit, a step that closes the scan and a result step; a mark adds a table
// write-back, a refused split ends its scan early, and a zero-length mark
// ends its scan at once. A clear goes from acceptance straight to its result.
// Stalls on rsp hold an item in its result step. Total_limit is written
// through cfg and applies on the next clear; reset restores its default. A
// refused split leaves the table and sets status.
module missing_range_tracker #(
  parameter int MAX_GAPS    = mrt_pkg::MaxGaps,
  parameter int OFFSET_BITS = mrt_pkg::OffsetBits
) (
  input wire logic clk,
  input wire logic rst,
  mrt_if.sink      cmd,
  mrt_if.sink      cfg,
  mrt_if.source    rsp
);
  mrt_pkg::dp_cmd_t dcmd;
  mrt_pkg::dp_sts_t dsts;
  logic status, available, next_valid;
  logic [OFFSET_BITS-1:0] next_offset;

  assign cfg.ready = 1'b1;
  assign rsp.data  = {status, available, next_offset, next_valid};

  mrt_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(cmd.valid), .in_ready(cmd.ready),
    .in_func(cmd.data[OFFSET_BITS+mrt_pkg::LengthBits+1 -: 2]),
    .out_valid(rsp.valid), .out_ready(rsp.ready), .cmd(dcmd), .sts(dsts)
  );

  mrt_dp #(.MAX_GAPS(MAX_GAPS), .OFFSET_BITS(OFFSET_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(dcmd), .sts(dsts),
    .in_func(cmd.data[OFFSET_BITS+mrt_pkg::LengthBits+1 -: 2]),
    .in_offset(cmd.data[OFFSET_BITS+mrt_pkg::LengthBits-1 -: OFFSET_BITS]),
    .in_length(cmd.data[mrt_pkg::LengthBits-1:0]),
    .cfg_valid(cfg.valid), .cfg_data(cfg.data[OFFSET_BITS-1:0]),
    .status(status), .available(available),
    .next_offset(next_offset), .next_valid(next_valid)
  );
endmodule
`default_nettype wire

// File: hw/rtl/mrt_ctrl.sv
// Controller state machine of the missing range tracker.
`timescale 1ns / 1ps
`default_nettype none
module mrt_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [1:0]          in_func,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output mrt_pkg::dp_cmd_t         cmd,
  input  wire mrt_pkg::dp_sts_t    sts
);
  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_COPY, S_OUT} state_t;
  state_t state;
  logic [1:0] func;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        cmd.load  = in_valid;
        cmd.start = in_valid;
        cmd.clear = in_valid && (in_func == mrt_pkg::FUNC_CLEAR);
      end
      S_SCAN: cmd.scan = !sts.scan_done;
      S_COPY: cmd.commit = 1'b1;
      S_OUT: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      func  <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (in_valid) begin
          func  <= in_func;
          state <= (in_func == mrt_pkg::FUNC_CLEAR) ? S_OUT : S_SCAN;
        end
        S_SCAN: if (sts.scan_done) begin
          state <= (func == mrt_pkg::FUNC_MARK && !sts.refuse) ? S_COPY : S_OUT;
        end
        S_COPY: if (sts.copy_done) state <= S_OUT;
        S_OUT: if (out_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: hw/rtl/mrt_dp.sv
// Datapath: gap table, scan unit and result registers.
`timescale 1ns / 1ps
`default_nettype none
module mrt_dp #(
  parameter int MAX_GAPS    = mrt_pkg::MaxGaps,
  parameter int OFFSET_BITS = mrt_pkg::OffsetBits
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire mrt_pkg::dp_cmd_t             cmd,
  output mrt_pkg::dp_sts_t                  sts,
  input  wire logic [1:0]                   in_func,
  input  wire logic [OFFSET_BITS-1:0]       in_offset,
  input  wire logic [mrt_pkg::LengthBits-1:0] in_length,
  input  wire logic                         cfg_valid,
  input  wire logic [OFFSET_BITS-1:0]       cfg_data,
  output logic                              status,
  output logic                              available,
  output logic [OFFSET_BITS-1:0]            next_offset,
  output logic                              next_valid
);
  localparam int IW = $clog2(MAX_GAPS);
  localparam int CW = $clog2(MAX_GAPS + 1);
  localparam int EW = OFFSET_BITS + 1;

  logic [OFFSET_BITS-1:0] limit;
  logic [OFFSET_BITS-1:0] gs [MAX_GAPS];
  logic [OFFSET_BITS-1:0] ge [MAX_GAPS];
  logic [OFFSET_BITS-1:0] ns [MAX_GAPS];
  logic [OFFSET_BITS-1:0] ne [MAX_GAPS];
  logic [CW-1:0] count, idx, wcnt;
  logic [1:0] func;
  logic [EW-1:0] ws, we;
  logic found, refuse;

  logic [EW-1:0] cs, ce;
  logic sep, left, right, full, over;
  logic [IW-1:0] ri, wi, wi1;

  assign ri  = idx[IW-1:0];
  assign wi  = wcnt[IW-1:0];
  assign wi1 = wi + IW'(1);
  assign cs  = {1'b0, gs[ri]};
  assign ce  = {1'b0, ge[ri]};
  assign sep   = (we <= cs) || (ws >= ce);
  assign left  = ws > cs;
  assign right = we < ce;
  assign full  = (count == CW'(MAX_GAPS));
  assign over  = !sep && (ws > cs) && (we < ce);

  assign sts.scan_done = (idx >= count) || (func == mrt_pkg::FUNC_MARK && refuse);
  assign sts.copy_done = 1'b1;
  assign sts.refuse    = refuse;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= OFFSET_BITS'(mrt_pkg::LimitReset);
      count <= CW'(1);
      gs[0] <= '0;
      ge[0] <= OFFSET_BITS'(mrt_pkg::LimitReset);
    end else begin
      if (cfg_valid) limit <= cfg_data;
      if (cmd.load) begin
        func        <= in_func;
        ws          <= {1'b0, in_offset};
        we          <= {1'b0, in_offset} + EW'(in_length);
        status      <= 1'b0;
        available   <= (in_func == mrt_pkg::FUNC_CHECK);
        next_offset <= '0;
        next_valid  <= 1'b0;
        found       <= 1'b0;
        refuse      <= 1'b0;
      end
      if (cmd.start) begin
        idx         <= '0;
        wcnt        <= '0;
      end
      if (cmd.clear) begin
        gs[0] <= '0;
        ge[0] <= limit;
        count <= (limit != '0) ? CW'(1) : '0;
      end
      if (cmd.scan) begin
        // A zero-length mark keeps the whole table and ends the scan at once.
        if (func == mrt_pkg::FUNC_MARK && we <= ws) idx <= count;
        else idx <= idx + CW'(1);
        unique case (func)
          mrt_pkg::FUNC_CHECK: if (cs < we && ws < ce) available <= 1'b0;
          mrt_pkg::FUNC_FIND: begin
            if (!found && ce > ws) begin
              found       <= 1'b1;
              next_valid  <= 1'b1;
              next_offset <= (cs <= ws) ? ws[OFFSET_BITS-1:0] : gs[ri];
            end else if (!found && idx == '0) begin
              // Wrap value; replaced if a later entry qualifies.
              next_valid  <= 1'b1;
              next_offset <= gs[ri];
            end
          end
          default: begin
            if (we <= ws) begin
              wcnt <= count;
              for (int k = 0; k < MAX_GAPS; k++) begin
                ns[k] <= gs[k];
                ne[k] <= ge[k];
              end
            end else if (over && full) begin
              refuse <= 1'b1;
              status <= 1'b1;
            end else if (sep) begin
              ns[wi] <= gs[ri]; ne[wi] <= ge[ri]; wcnt <= wcnt + CW'(1);
            end else if (left && right) begin
              ns[wi] <= gs[ri]; ne[wi] <= ws[OFFSET_BITS-1:0];
              ns[wi1] <= we[OFFSET_BITS-1:0]; ne[wi1] <= ge[ri];
              wcnt <= wcnt + CW'(2);
            end else if (left) begin
              ns[wi] <= gs[ri]; ne[wi] <= ws[OFFSET_BITS-1:0];
              wcnt <= wcnt + CW'(1);
            end else if (right) begin
              ns[wi] <= we[OFFSET_BITS-1:0]; ne[wi] <= ge[ri];
              wcnt <= wcnt + CW'(1);
            end
          end
        endcase
      end
      if (cmd.commit) begin
        for (int k = 0; k < MAX_GAPS; k++) begin
          gs[k] <= ns[k];
          ge[k] <= ne[k];
        end
        count <= wcnt;
      end
    end
  end
endmodule
`default_nettype wire

// File: test/testbench.sv
// Self-checking testbench for the missing range tracker.
`timescale 1ns / 1ps
`default_nettype none

typedef struct packed {
  mrt_pkg::func_t func;
  logic [39:0]    offset;
  logic [31:0]    length;
} gap_cmd_t;

typedef struct packed {
  logic        status;
  logic        available;
  logic [39:0] next_offset;
  logic        next_valid;
} gap_rsp_t;

class gap_table_scoreboard;
  logic [39:0] limit;
  logic [39:0] gap_lo[mrt_pkg::MaxGaps];
  logic [39:0] gap_hi[mrt_pkg::MaxGaps];
  int          gap_num;
  gap_rsp_t    pending[$];
  int          errors;

  function void reload();
    gap_lo[0] = '0;
    gap_hi[0] = limit;
    gap_num = (limit != 0) ? 1 : 0;
  endfunction

  function void power_up();
    limit = mrt_pkg::LimitReset;
    errors = 0;
    reload();
  endfunction

  // Removes [lo, hi) from the table; returns 1 when a split is refused.
  function logic remove_range(logic [40:0] lo, logic [40:0] hi);
    logic [39:0] new_lo[mrt_pkg::MaxGaps + 1];
    logic [39:0] new_hi[mrt_pkg::MaxGaps + 1];
    int n;
    n = 0;
    if (hi <= lo) return 1'b0;
    for (int i = 0; i < gap_num; i++)
      if (lo > gap_lo[i] && hi < gap_hi[i] && gap_num >= mrt_pkg::MaxGaps) return 1'b1;
    for (int i = 0; i < gap_num; i++) begin
      if (hi <= gap_lo[i] || lo >= gap_hi[i]) begin
        new_lo[n] = gap_lo[i]; new_hi[n] = gap_hi[i]; n++;
      end else begin
        if (lo > gap_lo[i]) begin
          new_lo[n] = gap_lo[i]; new_hi[n] = lo[39:0]; n++;
        end
        if (hi < gap_hi[i]) begin
          new_lo[n] = hi[39:0]; new_hi[n] = gap_hi[i]; n++;
        end
      end
    end
    if (n > mrt_pkg::MaxGaps) n = mrt_pkg::MaxGaps;
    for (int i = 0; i < n; i++) begin
      gap_lo[i] = new_lo[i];
      gap_hi[i] = new_hi[i];
    end
    gap_num = n;
    return 1'b0;
  endfunction

  function void note_cmd(gap_cmd_t c);
    gap_rsp_t    r;
    logic [40:0] stop;
    r = '0;
    stop = {1'b0, c.offset} + {9'd0, c.length};
    case (c.func)
      mrt_pkg::FUNC_MARK: r.status = remove_range({1'b0, c.offset}, stop);
      mrt_pkg::FUNC_CHECK: begin
        r.available = 1'b1;
        for (int i = 0; i < gap_num; i++)
          if (gap_lo[i] < stop && c.offset < gap_hi[i]) r.available = 1'b0;
      end
      mrt_pkg::FUNC_FIND: begin
        for (int i = 0; i < gap_num; i++) begin
          if (gap_hi[i] > c.offset) begin
            r.next_offset = (gap_lo[i] <= c.offset) ? c.offset : gap_lo[i];
            r.next_valid = 1'b1;
            break;
          end
        end
        // Nothing ends past the position: wrap to the first gap.
        if (!r.next_valid && gap_num > 0) begin
          r.next_offset = gap_lo[0];
          r.next_valid = 1'b1;
        end
      end
      default: reload();
    endcase
    pending.push_back(r);
  endfunction

  function void check_rsp(gap_rsp_t got);
    gap_rsp_t want;
    if (pending.size() == 0) begin
      $error("unexpected response %h", got);
      errors++;
      return;
    end
    want = pending.pop_front();
    if (got.status !== want.status) begin
      $error("status: expected %h, got %h", want.status, got.status); errors++;
    end
    if (got.available !== want.available) begin
      $error("available: expected %h, got %h", want.available, got.available); errors++;
    end
    if (got.next_offset !== want.next_offset) begin
      $error("next_offset: expected %h, got %h", want.next_offset, got.next_offset);
      errors++;
    end
    if (got.next_valid !== want.next_valid) begin
      $error("next_valid: expected %h, got %h", want.next_valid, got.next_valid); errors++;
    end
  endfunction
endclass

module testbench;
  logic clk = 1'b0;
  logic rst = 1'b1;
  int   src_idle_pct = 34;
  int   snk_idle_pct = 56;
  logic [39:0] cur_limit = mrt_pkg::LimitReset;
  gap_table_scoreboard sb = new();

  mrt_if #(74) cmd_ch (clk);
  mrt_if #(40) cfg_ch (clk);
  mrt_if #(43) rsp_ch (clk);

  missing_range_tracker i_dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_ch.sink),
    .cfg(cfg_ch.sink),
    .rsp(rsp_ch.source)
  );

  always #4 clk = ~clk;

  initial begin
    cmd_ch.valid = 1'b0;
    cmd_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    rsp_ch.ready = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready) sb.check_rsp(gap_rsp_t'(rsp_ch.data));
      rsp_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  task automatic send_cmd(mrt_pkg::func_t f, logic [39:0] off, logic [31:0] len);
    gap_cmd_t c;
    c.func = f;
    c.offset = off;
    c.length = len;
    while ($urandom_range(99) < src_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.data <= c;
    do @(posedge clk); while (!cmd_ch.ready);
    sb.note_cmd(c);
  endtask

  // Waits for the table to go quiet, then writes the limit register.
  task automatic write_limit(logic [39:0] value);
    cmd_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    sb.limit = value;
    cur_limit = value;
  endtask

  task automatic random_cmd();
    int          pick;
    logic [39:0] off;
    logic [31:0] len;
    logic [39:0] span;
    pick = $urandom_range(99);
    span = (cur_limit > 40'd4000) ? 40'd4000 : cur_limit;
    if ($urandom_range(9) == 0) begin
      off = 40'({$urandom, $urandom});
      len = $urandom;
      // Near the end of the table, so the wide values still hit something.
      if ($urandom_range(1)) off = cur_limit - off[11:0];
    end else begin
      off = 40'($urandom_range(32'(span) + 32'd8));
      if (cur_limit > 40'd4000 && $urandom_range(1)) off = cur_limit - off;
      len = $urandom_range(32'd1, 32'(1 + span / 10));
    end
    if (pick < 45) send_cmd(mrt_pkg::FUNC_MARK, off, len);
    else if (pick < 70) send_cmd(mrt_pkg::FUNC_CHECK, off, len);
    else if (pick < 97) send_cmd(mrt_pkg::FUNC_FIND, off, len);
    else send_cmd(mrt_pkg::FUNC_CLEAR, off, len);
  endtask

  initial begin
    logic [39:0] limits[6];
    limits = '{40'd1, 40'd300, 40'd2500, 40'hFF_FFFF_FFFF, 40'd60, 40'h80_0000_0000};
    sb.power_up();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: full-size table, splits up to a full table, wide ranges.
    send_cmd(mrt_pkg::FUNC_FIND, 40'd0, 32'd1);
    send_cmd(mrt_pkg::FUNC_CHECK, 40'd0, 32'd1);
    send_cmd(mrt_pkg::FUNC_CHECK, 40'd5, 32'd0);
    send_cmd(mrt_pkg::FUNC_MARK, 40'd5, 32'd0);
    for (int k = 0; k < 16; k++)
      send_cmd(mrt_pkg::FUNC_MARK, 40'(100 * k + 10), 32'd5);
    send_cmd(mrt_pkg::FUNC_MARK, 40'hFF_FFFF_0000, 32'hFFFF_FFFF);
    send_cmd(mrt_pkg::FUNC_FIND, 40'hFF_FFFF_FFFF, 32'hFFFF_FFFF);
    send_cmd(mrt_pkg::FUNC_CHECK, 40'hFF_FFFF_0000, 32'hFFFF_FFFF);
    send_cmd(mrt_pkg::FUNC_CLEAR, 40'hFF_FFFF_FFFF, 32'hFFFF_FFFF);

    // One-byte limit: empty table after a single mark.
    write_limit(40'd1);
    send_cmd(mrt_pkg::FUNC_CLEAR, 40'd0, 32'd1);
    send_cmd(mrt_pkg::FUNC_MARK, 40'd0, 32'd1);
    send_cmd(mrt_pkg::FUNC_FIND, 40'd0, 32'd1);
    send_cmd(mrt_pkg::FUNC_CHECK, 40'd0, 32'd1);

    for (int n = 0; n < 1530; n++) begin
      if (n == 510) begin
        src_idle_pct = 56; snk_idle_pct = 34;
      end else if (n == 1020) begin
        src_idle_pct = 0; snk_idle_pct = 0;
      end
      if (n % 255 == 0) begin
        write_limit(limits[(n / 255) % 6]);
        send_cmd(mrt_pkg::FUNC_CLEAR, 40'd0, 32'd1);
      end
      random_cmd();
    end
    cmd_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (sb.errors == 0) $display("testbench: PASS");
    else $display("testbench: FAIL");
    $finish;
  end

  initial begin
    #20ms;
    $display("testbench: FAIL");
    $finish;
  end
endmodule
`default_nettype wire
